// File: hw/rtl/ifsa_pkg.sv
// Shared types, constants and codes of the integer field statistics accumulator.
`default_nettype none
package ifsa_pkg;
   localparam int TableEntries = 10;
   localparam int IdxWidth     = $clog2(TableEntries);
   localparam int CntWidth     = $clog2(TableEntries + 1);
   localparam int SumWidth     = 64;
   localparam logic [31:0] CntMax = 32'hFFFF_FFFF;

   localparam logic [1:0] ModeAdd    = 2'd0;
   localparam logic [1:0] ModeReport = 2'd1;
   localparam logic [1:0] ModeClear  = 2'd2;
   localparam logic [1:0] ModeSpare  = 2'd3;

   localparam logic KindSummary = 1'b0;
   localparam logic KindEntry   = 1'b1;

   // Controller commands to the datapath.
   typedef struct packed {
      logic do_add;
      logic do_clear;
      logic div_start;
      logic sort_start;
      logic sort_step;
      logic load_summary;
      logic load_entry;
   } ctrl_type;

   // Datapath status back to the controller.
   typedef struct packed {
      logic div_done;
      logic sort_done;
      logic [CntWidth-1:0] used;
      logic [CntWidth-1:0] emitted;
   } stat_type;
endpackage
`default_nettype wire

// File: hw/rtl/ifsa_divider.sv
// Restoring divider for the mean: |sum|*256 / count, one quotient bit per cycle.
`default_nettype none
module ifsa_divider
   import ifsa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] sum,
   input  wire logic [31:0]        count,
   output logic                    done,
   output logic [39:0]             mean
);
   // Dividend is |sum|<<8: 72 bits, so 72 iterations.
   logic [71:0] dvd_ff, dvd_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff;
   logic        neg_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] mag;
   logic [33:0] trial;
   logic [32:0] shifted;

   assign mag     = sum[63] ? (64'd0 - sum) : sum;
   assign shifted = {rem_ff[31:0], dvd_ff[71]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};

   // Done stays high from the end of a division until the next start.
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         dvd_in  = {mag, 8'd0};
         rem_in  = '0;
         cnt_in  = 7'd72;
         busy_in = (count != 32'd0);
         done_in = (count == 32'd0);
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
            dvd_in = {dvd_ff[70:0], 1'b1};
         end else begin
            rem_in = shifted;
            dvd_in = {dvd_ff[70:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= count;
         neg_ff <= sum[63] && (count != 32'd0);
      end
   end

   // Quotient fits 72 bits; only its low 40 are kept, a zero count gives zero.
   always_comb begin
      if (den_ff == 32'd0) mean = '0;
      else if (neg_ff) mean = 40'd0 - dvd_ff[39:0];
      else mean = dvd_ff[39:0];
   end
   assign done = done_ff;
endmodule
`default_nettype wire

// File: hw/rtl/ifsa_datapath.sv
// Accumulators, distribution table, report sorter and output register.
`default_nettype none
module ifsa_datapath
   import ifsa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctrl_type           ctrl,
   output stat_type                stat,
   input  wire logic signed [31:0] in_value,
   input  wire logic               in_bad,
   output logic                    o_kind,
   output logic [31:0]             o_good,
   output logic [31:0]             o_bad,
   output logic signed [31:0]      o_min,
   output logic signed [31:0]      o_max,
   output logic signed [39:0]      o_mean,
   output logic signed [31:0]      o_value,
   output logic [31:0]             o_count,
   output logic [31:0]             o_count_sum,
   output logic                    o_last
);
   logic [31:0]        good_ff, bad_ff;
   logic signed [63:0] sum_ff;
   logic signed [31:0] min_ff, max_ff;
   logic signed [31:0] val_ff [TableEntries];
   logic [31:0]        cnt_ff [TableEntries];
   logic [CntWidth-1:0] used_ff;
   logic [TableEntries-1:0] hit;

   // Sort state: sel marks entries already emitted; picks the smallest remaining.
   logic [TableEntries-1:0] sel_ff;
   logic [CntWidth-1:0]     emit_ff;
   logic [32:0]             csum_ff;
   logic [CntWidth-1:0]     scan_ff;
   logic                    scanning_ff;
   logic                    have_ff;
   logic [IdxWidth-1:0]     best_ff;

   logic        div_done;
   logic [39:0] mean;

   ifsa_divider u_div (
      .clock(clock), .reset(reset), .start(ctrl.div_start),
      .sum(sum_ff), .count(good_ff), .done(div_done), .mean(mean)
   );

   always_comb begin
      for (int i = 0; i < TableEntries; i++)
         hit[i] = (CntWidth'(i) < used_ff) && (val_ff[i] == in_value);
   end

   logic [IdxWidth-1:0] scan_idx;
   assign scan_idx = scan_ff[IdxWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset || ctrl.do_clear) begin
         good_ff <= '0; bad_ff <= '0; sum_ff <= '0;
         min_ff <= '0; max_ff <= '0; used_ff <= '0;
      end else if (ctrl.do_add) begin
         if (in_bad) begin
            if (bad_ff != CntMax) bad_ff <= bad_ff + 32'd1;
         end else if (good_ff != CntMax) begin
            good_ff <= good_ff + 32'd1;
            sum_ff  <= sum_ff + 64'(in_value);
            if (good_ff == 32'd0) begin
               min_ff <= in_value; max_ff <= in_value;
            end else if (in_value < min_ff) min_ff <= in_value;
            else if (in_value > max_ff) max_ff <= in_value;
            if (hit == '0 && used_ff < CntWidth'(TableEntries)) begin
               val_ff[used_ff[IdxWidth-1:0]] <= in_value;
               cnt_ff[used_ff[IdxWidth-1:0]] <= 32'd1;
               used_ff <= used_ff + 1'b1;
            end
            for (int i = 0; i < TableEntries; i++)
               if (hit[i] && cnt_ff[i] != CntMax) cnt_ff[i] <= cnt_ff[i] + 32'd1;
         end
      end
   end

   // One entry examined per cycle; the count sum is gathered on the first pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         scanning_ff <= 1'b0;
         sel_ff <= '0; emit_ff <= '0; scan_ff <= '0; have_ff <= 1'b0;
         csum_ff <= '0; best_ff <= '0;
      end else if (ctrl.sort_start) begin
         sel_ff <= '0; emit_ff <= '0; scan_ff <= '0; have_ff <= 1'b0;
         csum_ff <= '0; scanning_ff <= 1'b1;
      end else if (ctrl.sort_step) begin
         scan_ff <= '0; have_ff <= 1'b0; scanning_ff <= 1'b1;
         sel_ff[best_ff] <= 1'b1;
         emit_ff <= emit_ff + 1'b1;
      end else if (scanning_ff) begin
         if (scan_ff < used_ff) begin
            if (emit_ff == '0) begin
               if (csum_ff + {1'b0, cnt_ff[scan_idx]} > {1'b0, CntMax})
                  csum_ff <= {1'b0, CntMax};
               else csum_ff <= csum_ff + {1'b0, cnt_ff[scan_idx]};
            end
            if (!sel_ff[scan_idx] && (!have_ff || val_ff[scan_idx] < val_ff[best_ff])) begin
               best_ff <= scan_idx; have_ff <= 1'b1;
            end
            scan_ff <= scan_ff + 1'b1;
         end else scanning_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_summary) begin
         o_kind <= KindSummary; o_good <= good_ff; o_bad <= bad_ff;
         o_min <= min_ff; o_max <= max_ff; o_mean <= mean;
         o_value <= '0; o_count <= '0; o_count_sum <= csum_ff[31:0];
         o_last <= (used_ff == '0);
      end else if (ctrl.load_entry) begin
         o_kind <= KindEntry; o_good <= '0; o_bad <= '0;
         o_min <= '0; o_max <= '0; o_mean <= '0;
         o_value <= val_ff[best_ff]; o_count <= cnt_ff[best_ff];
         o_count_sum <= '0; o_last <= (emit_ff + 1'b1 == used_ff);
      end
   end

   assign stat.div_done  = div_done;
   assign stat.sort_done = !scanning_ff;
   assign stat.used      = used_ff;
   assign stat.emitted   = emit_ff;
endmodule
`default_nettype wire

// File: hw/rtl/ifsa_controller.sv
// Controller state machine: accepts items, sequences report records and handshakes.
`default_nettype none
module ifsa_controller
   import ifsa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_mode,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output ctrl_type        ctrl,
   input  wire stat_type   stat
);
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StWork = 3'd1;
   localparam logic [2:0] StSum  = 3'd2;
   localparam logic [2:0] StScan = 3'd3;
   localparam logic [2:0] StEnt  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       accept;

   assign req_ready = (state_ff == StIdle);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_ready;
      ctrl     = '0;
      unique case (state_ff) inside
         StIdle: begin
            if (accept) begin
               ctrl.do_add   = (req_mode == ModeAdd);
               ctrl.do_clear = (req_mode == ModeClear);
               if (req_mode == ModeReport) begin
                  ctrl.div_start  = 1'b1;
                  ctrl.sort_start = 1'b1;
                  state_in = StWork;
               end
            end
         end
         StWork: if (stat.div_done && stat.sort_done) begin
            ctrl.load_summary = 1'b1;
            valid_in = 1'b1;
            state_in = StSum;
         end
         StSum, StEnt: if (!valid_in) begin
            if (stat.emitted == stat.used && state_ff == StEnt) state_in = StIdle;
            else if (state_ff == StSum && stat.used == '0) state_in = StIdle;
            else state_in = StScan;
         end
         StScan: if (stat.sort_done) begin
            ctrl.load_entry = 1'b1;
            ctrl.sort_step  = 1'b1;
            valid_in = 1'b1;
            state_in = StEnt;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/int_field_statistics_accumulator.sv
// Top level of the integer field statistics accumulator.
// Add, clear and unused-mode beats are handled on acceptance and leave the block
// idle, so between reports a stream of samples is accepted at one beat per cycle.
// A report runs a bit-serial divider for the mean in parallel with a scan of the
// value table; the summary record is offered once both have finished. The table
// entries follow in ascending order, each found by a scan over the n filled
// entries. No item is accepted until the last record of a report has left.
`default_nettype none
module int_field_statistics_accumulator
   import ifsa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_mode,
   input  wire logic signed [31:0] req_sample_value,
   input  wire logic               req_is_error,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_record_kind,
   output logic [31:0]             rsp_good_total,
   output logic [31:0]             rsp_bad_total,
   output logic signed [31:0]      rsp_min_seen,
   output logic signed [31:0]      rsp_max_seen,
   output logic signed [39:0]      rsp_mean_fixed,
   output logic signed [31:0]      rsp_entry_value,
   output logic [31:0]             rsp_entry_count,
   output logic [31:0]             rsp_entry_count_sum,
   output logic                    rsp_last_item
);
   ctrl_type ctrl;
   stat_type stat;

   ifsa_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_mode(req_mode), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .ctrl(ctrl), .stat(stat)
   );

   ifsa_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .in_value(req_sample_value), .in_bad(req_is_error),
      .o_kind(rsp_record_kind), .o_good(rsp_good_total), .o_bad(rsp_bad_total),
      .o_min(rsp_min_seen), .o_max(rsp_max_seen), .o_mean(rsp_mean_fixed),
      .o_value(rsp_entry_value), .o_count(rsp_entry_count),
      .o_count_sum(rsp_entry_count_sum), .o_last(rsp_last_item)
   );

   // No input beat is taken while a record is waiting.
   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input accepted during report");

   // The table never holds more than its capacity.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      stat.used <= CntWidth'(TableEntries)) else $error("table overfilled");

   // A record stays offered until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_value))
      else $error("record dropped");
endmodule
`default_nettype wire
